// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define AST_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle implies the consequent in the next
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/lcwr_pkg.sv -----
// package of shared constants for the load cell weight reader
package lcwr_pkg;

	localparam int ADC_BITS_DEF       = 24;
	localparam int GAIN_FRAC_BITS_DEF = 32;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int NET_W      = 33;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARE   = 2'd2;

	localparam logic [CFG_DATA_W-1:0] GAIN_RESET = 32'd6335301;
	localparam logic [CFG_DATA_W-1:0] TARE_RESET = 32'd0;

endpackage

// ----- sv/lcwr_in_if.sv -----
// request channel carrying the sampled converter data line
interface lcwr_in_if;

	logic valid;
	logic ready;
	logic dout_level;

	modport source (output valid, output dout_level, input ready);
	modport sink   (input valid, input dout_level, output ready);

endinterface

// ----- sv/lcwr_out_if.sv -----
// result channel carrying clock level and weight
interface lcwr_out_if import lcwr_pkg::*; ();

	logic                    valid;
	logic                    ready;
	logic                    sck_level;
	logic                    weight_valid;
	logic                    above_tare;
	logic signed [NET_W-1:0] net_weight;

	modport source (output valid, output sck_level, output weight_valid,
		output above_tare, output net_weight, input ready);
	modport sink   (input valid, input sck_level, input weight_valid,
		input above_tare, input net_weight, output ready);

endinterface

// ----- sv/load_cell_weight_reader_core.sv -----
// top level of the load cell weight reader
//
// each request on sample is one half-bit tick of the serial link and carries
// the level read on the converter data line; each request gives exactly one
// result on result: the clock level to drive for that tick, and on the tick
// that closes a reading the weight fields
// the serial state machine steps on acceptance; the reading then passes a
// multiply stage and a tare compare stage, registered in stage 1, stage 2
// and stage 3; one request per cycle is taken while result is not stalled
// the tare decision of the first reading of a pair feeds back from the
// compare stage, well ahead of the next reading's last tick
// cfg_we, cfg_index and cfg_data write enable, gain and tare; write only
// while no request is in flight
// reset clears the pipeline, idles the link with the clock low and loads the
// register defaults
// when result is stalled the stages fill up in turn and sample.ready drops
// only once all three hold a request
module load_cell_weight_reader_core import lcwr_pkg::*; #(
	parameter int ADC_BITS       = ADC_BITS_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lcwr_in_if.sink               sample,
	lcwr_out_if.source            result
);

	localparam int CNT_W    = $clog2(ADC_BITS + 1);
	localparam int PROD_W   = ADC_BITS + CFG_DATA_W;
	localparam int SHIFT    = GAIN_FRAC_BITS - 8;
	localparam int SCALED_W = PROD_W - SHIFT;
	localparam int CMP_W    = ((SCALED_W > CFG_DATA_W) ? SCALED_W : CFG_DATA_W) + 1;
	localparam logic [ADC_BITS-1:0] TOP_BIT = {1'b1, {(ADC_BITS-1){1'b0}}};

	localparam logic [2:0] PH_WAIT  = 3'd0;
	localparam logic [2:0] PH_HIGH  = 3'd1;
	localparam logic [2:0] PH_LOW   = 3'd2;
	localparam logic [2:0] PH_XHIGH = 3'd3;
	localparam logic [2:0] PH_XLOW  = 3'd4;

	logic                  enable_q;
	logic [CFG_DATA_W-1:0] gain_q;
	logic [CFG_DATA_W-1:0] tare_q;

	logic [2:0]          phase_q, phase_d;
	logic [CNT_W-1:0]    bit_count_q, bit_count_d, cnt_inc;
	logic [ADC_BITS-1:0] shift_q, shift_d;
	logic                second_read_q;
	logic                sck_d, xlow_d;

	logic                v1_s1, v2_s2, v3_s3;
	logic                sck_s1, xlow_s1, second_s1;
	logic [ADC_BITS-1:0] reading_s1;
	logic                sck_s2, xlow_s2, second_s2;
	logic [SCALED_W-1:0] scaled_s2;
	logic                sck_s3, wv_s3, above_s3;
	logic signed [NET_W-1:0] net_s3;

	logic                adv1, adv2, adv3, accept;
	logic [PROD_W-1:0]   prod;
	logic [CMP_W-1:0]    scaled_x, tare_x, diff;
	logic                above_cmp;

	// stage handshake
	assign adv3   = !v3_s3 || result.ready;
	assign adv2   = !v2_s2 || adv3;
	assign adv1   = !v1_s1 || adv2;
	assign accept = sample.valid && adv1;
	assign sample.ready = adv1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			gain_q   <= GAIN_RESET;
			tare_q   <= TARE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_GAIN:   gain_q   <= cfg_data;
				REG_TARE:   tare_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// serial link sequencer
	always_comb begin
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		shift_d     = shift_q;
		sck_d       = 1'b0;
		xlow_d      = 1'b0;
		cnt_inc     = bit_count_q + 1'b1;
		if (!enable_q) begin
			phase_d     = PH_WAIT;
			bit_count_d = '0;
			shift_d     = '0;
		end else begin
			case (phase_q)
				PH_HIGH: begin
					sck_d   = 1'b1;
					phase_d = PH_LOW;
				end
				PH_LOW: begin
					shift_d     = {shift_q[ADC_BITS-2:0], sample.dout_level};
					bit_count_d = cnt_inc;
					phase_d     = (cnt_inc >= CNT_W'(ADC_BITS)) ? PH_XHIGH : PH_HIGH;
				end
				PH_XHIGH: begin
					sck_d   = 1'b1;
					phase_d = PH_XLOW;
				end
				PH_XLOW: begin
					xlow_d      = 1'b1;
					bit_count_d = '0;
					shift_d     = '0;
					phase_d     = PH_WAIT;
				end
				default: begin
					phase_d = PH_WAIT;
					if (!sample.dout_level) begin
						bit_count_d = '0;
						shift_d     = '0;
						phase_d     = PH_HIGH;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			bit_count_q <= '0;
			shift_q     <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			bit_count_q <= bit_count_d;
			shift_q     <= shift_d;
		end
	end

	// pair tracking, fed back from the compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_read_q <= 1'b0;
		end else if (accept && !enable_q) begin
			second_read_q <= 1'b0;
		end else if (v2_s2 && adv3 && xlow_s2) begin
			second_read_q <= !second_s2 && above_cmp;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (adv1) v1_s1 <= sample.valid;
			if (adv2) v2_s2 <= v1_s1;
			if (adv3) v3_s3 <= v2_s2;
		end
	end

	// stage 1: tick outcome and offset binary reading
	always_ff @(posedge clk) begin
		if (accept) begin
			sck_s1     <= sck_d;
			xlow_s1    <= xlow_d;
			second_s1  <= second_read_q;
			reading_s1 <= shift_q ^ TOP_BIT;
		end
	end

	// stage 2: gain scaling
	assign prod = PROD_W'(reading_s1) * PROD_W'(gain_q);

	always_ff @(posedge clk) begin
		if (v1_s1 && adv2) begin
			sck_s2    <= sck_s1;
			xlow_s2   <= xlow_s1;
			second_s2 <= second_s1;
			scaled_s2 <= prod[PROD_W-1:SHIFT];
		end
	end

	// stage 3: tare compare and net weight
	assign scaled_x  = CMP_W'(scaled_s2);
	assign tare_x    = CMP_W'(tare_q);
	assign above_cmp = scaled_x > tare_x;
	assign diff      = scaled_x - tare_x;

	always_ff @(posedge clk) begin
		if (v2_s2 && adv3) begin
			sck_s3   <= sck_s2;
			wv_s3    <= 1'b0;
			above_s3 <= 1'b0;
			net_s3   <= '0;
			if (xlow_s2) begin
				if (second_s2) begin
					wv_s3    <= 1'b1;
					above_s3 <= 1'b1;
					net_s3   <= $signed(diff[NET_W-1:0]);
				end else if (!above_cmp) begin
					wv_s3 <= 1'b1;
				end
			end
		end
	end

	assign result.valid        = v3_s3;
	assign result.sck_level    = sck_s3;
	assign result.weight_valid = wv_s3;
	assign result.above_tare   = above_s3;
	assign result.net_weight   = net_s3;

endmodule

// ----- sv/lcwr_checker.sv -----
// port checker for the load cell weight reader, bound to the top level
`include "assert_macros.svh"

module lcwr_checker import lcwr_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    res_valid,
	input logic                    res_ready,
	input logic                    sck_level,
	input logic                    weight_valid,
	input logic                    above_tare,
	input logic signed [NET_W-1:0] net_weight
);

	`AST_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(net_weight) && $stable(weight_valid), "stalled result changed")
	`AST_HOLDS(a_idle_zero, !res_valid || weight_valid || (!above_tare && net_weight == '0), "weight fields set without a weight")
	`AST_HOLDS(a_above_valid, !res_valid || !above_tare || weight_valid, "above tare without a weight")
	`AST_HOLDS(a_weight_low, !res_valid || !weight_valid || !sck_level, "weight given on a clock high tick")

endmodule

bind load_cell_weight_reader_core lcwr_checker u_lcwr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.sck_level    (result.sck_level),
	.weight_valid (result.weight_valid),
	.above_tare   (result.above_tare),
	.net_weight   (result.net_weight)
);

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the load cell weight reader core
`timescale 1ns / 1ps

module tb_top;
	import lcwr_pkg::*;

	localparam int  ADC_W        = ADC_BITS_DEF;
	localparam int  SETTLE_TICKS = 8;
	localparam real HALF_PERIOD  = 2.0;
	localparam logic [ADC_W-1:0] TOP_BIT = {1'b1, {(ADC_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_WAIT  = 3'd0,
		ST_HIGH  = 3'd1,
		ST_LOW   = 3'd2,
		ST_XHIGH = 3'd3,
		ST_XLOW  = 3'd4
	} link_phase_t;

	typedef struct packed {
		logic             sck;
		logic             weight_valid;
		logic             above;
		logic [NET_W-1:0] net;
	} tick_result_t;

	class weight_scoreboard;
		logic              enabled;
		logic [31:0]       gain_reg;
		logic [31:0]       tare_reg;
		link_phase_t       link_ph;
		logic [4:0]        bit_cnt;
		logic [ADC_W-1:0]  shift_reg;
		logic              awaiting_second;
		logic              first_over;
		tick_result_t      expected_ticks[$];
		int                errors;
		int                ticks;
		int                weights;
		int                over_cnt;
		int                neg_cnt;
		int                zero_cnt;

		function new();
			enabled = 1'b0;
			gain_reg = GAIN_RESET;
			tare_reg = TARE_RESET;
			errors = 0;
			ticks = 0;
			weights = 0;
			over_cnt = 0;
			neg_cnt = 0;
			zero_cnt = 0;
			drop_transfer();
		endfunction

		function void drop_transfer();
			link_ph = ST_WAIT;
			bit_cnt = '0;
			shift_reg = '0;
			awaiting_second = 1'b0;
			first_over = 1'b0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ENABLE: enabled = data[0];
				REG_GAIN:   gain_reg = data;
				REG_TARE:   tare_reg = data;
				default:    ;
			endcase
		endfunction

		function logic [NET_W-1:0] scaled_reading(logic [ADC_W-1:0] reading);
			logic [63:0] prod;
			prod = {{(64-ADC_W){1'b0}}, reading} * {32'd0, gain_reg};
			return NET_W'(prod >> (GAIN_FRAC_BITS_DEF - 8));
		endfunction

		function void note_tick(logic dout);
			tick_result_t     r;
			logic [ADC_W-1:0] reading;
			logic [NET_W-1:0] scaled;
			r = '0;
			ticks++;
			if (!enabled) begin
				drop_transfer();
			end else begin
				case (link_ph)
					ST_HIGH: begin
						r.sck = 1'b1;
						link_ph = ST_LOW;
					end
					ST_LOW: begin
						shift_reg = {shift_reg[ADC_W-2:0], dout};
						bit_cnt = bit_cnt + 5'd1;
						link_ph = (bit_cnt >= ADC_W) ? ST_XHIGH : ST_HIGH;
					end
					ST_XHIGH: begin
						r.sck = 1'b1;
						link_ph = ST_XLOW;
					end
					ST_XLOW: begin
						reading = shift_reg ^ TOP_BIT;
						scaled = scaled_reading(reading);
						if (!awaiting_second) begin
							first_over = (scaled > {1'b0, tare_reg});
							if (first_over) begin
								awaiting_second = 1'b1;
							end else begin
								r.weight_valid = 1'b1;
								zero_cnt++;
							end
						end else begin
							r.weight_valid = 1'b1;
							r.above = 1'b1;
							r.net = scaled - {1'b0, tare_reg};
							over_cnt++;
							if (r.net[NET_W-1])
								neg_cnt++;
							awaiting_second = 1'b0;
							first_over = 1'b0;
						end
						if (r.weight_valid)
							weights++;
						bit_cnt = '0;
						shift_reg = '0;
						link_ph = ST_WAIT;
					end
					default: begin
						link_ph = ST_WAIT;
						if (dout == 1'b0) begin
							bit_cnt = '0;
							shift_reg = '0;
							link_ph = ST_HIGH;
						end
					end
				endcase
			end
			expected_ticks.push_back(r);
		endfunction

		function void report(string what, tick_result_t want, tick_result_t got);
			errors++;
			if (errors <= 10)
				$display({"mismatch (%s): expected sck=%0b wv=%0b above=%0b net=%0d, ",
					"got sck=%0b wv=%0b above=%0b net=%0d"},
					what, want.sck, want.weight_valid, want.above, $signed(want.net),
					got.sck, got.weight_valid, got.above, $signed(got.net));
		endfunction

		function void check_result(logic sck, logic wv, logic above, logic [NET_W-1:0] net);
			tick_result_t want;
			tick_result_t got;
			got = {sck, wv, above, net};
			if (expected_ticks.size() == 0) begin
				report("no request outstanding", '0, got);
				return;
			end
			want = expected_ticks.pop_front();
			if (got.sck !== want.sck || got.weight_valid !== want.weight_valid ||
					got.above !== want.above || got.net !== want.net)
				report("result field", want, got);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  gaps_on;
	int                    settings;

	weight_scoreboard sb;

	lcwr_in_if  sample_if ();
	lcwr_out_if result_if ();

	load_cell_weight_reader_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_if),
		.result    (result_if)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic send_tick(input logic d);
		int g;
		g = gaps_on ? gap_len() : 0;
		repeat (g) begin
			@(negedge clk);
			sample_if.valid <= 1'b0;
		end
		@(negedge clk);
		sample_if.valid <= 1'b1;
		sample_if.dout_level <= d;
		do
			@(posedge clk);
		while (sample_if.ready !== 1'b1);
		sb.note_tick(d);
	endtask

	// hold off requests until every result is back
	task automatic settle();
		@(negedge clk);
		sample_if.valid <= 1'b0;
		while (sb.expected_ticks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one complete conversion, word shifted msb first on the low ticks
	task automatic send_reading(input logic [ADC_W-1:0] word);
		int  idx;
		logic d;
		while (sb.link_ph != ST_WAIT)
			send_tick(rand_bit());
		repeat ($urandom_range(0, 3)) send_tick(1'b1);
		send_tick(1'b0);
		idx = ADC_W - 1;
		while (sb.link_ph != ST_WAIT) begin
			if (sb.link_ph == ST_LOW) begin
				d = word[idx];
				idx--;
			end else begin
				d = rand_bit();
			end
			send_tick(d);
		end
	endtask

	// transfer cut short by dropping enable
	task automatic send_broken(input int len);
		send_tick(1'b0);
		repeat (len) send_tick(rand_bit());
		settle();
		write_reg(REG_ENABLE, 32'd0);
		repeat ($urandom_range(1, 5)) send_tick(rand_bit());
		settle();
		write_reg(REG_ENABLE, 32'd1);
	endtask

	function automatic logic [ADC_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		if (r < 8)
			return '1;
		if (r < 12)
			return TOP_BIT;
		if (r < 16)
			return ~TOP_BIT;
		return ADC_W'($urandom);
	endfunction

	initial begin
		result_if.ready = 1'b0;
		@(posedge arst_n);
		begin
			int span;
			int mode;
			int hold;
			hold = 0;
			forever begin
				span = $urandom_range(30, 300);
				mode = $urandom_range(0, 3);
				repeat (span) begin
					@(negedge clk);
					if (hold > 0) begin
						result_if.ready <= 1'b0;
						hold--;
					end else begin
						result_if.ready <= 1'b1;
						if (mode != 0)
							hold = gap_len();
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
			sb.check_result(result_if.sck_level, result_if.weight_valid,
				result_if.above_tare, result_if.net_weight);
	end

	initial begin
		#20000000;
		$display("load_cell_weight_reader_core regression: fail");
		$finish;
	end

	initial begin
		int          r;
		logic [31:0] g;
		logic [31:0] t;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data = '0;
		sample_if.valid = 1'b0;
		sample_if.dout_level = 1'b0;
		gaps_on = 1'b1;
		settings = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// disabled after reset: clock held low
		repeat (6) send_tick(rand_bit());
		settle();

		// default gain, zero tare: extremes of the word and pairs
		write_reg(REG_GAIN, GAIN_RESET);
		write_reg(REG_TARE, 32'd0);
		write_reg(REG_ENABLE, 32'd1);
		send_reading(24'h800000);
		send_reading(24'h7FFFFF);
		send_reading(24'hFFFFFF);
		send_reading(24'h000000);
		send_reading(24'h7FFFFF);
		settle();

		// second reading below tare gives a negative net
		write_reg(REG_TARE, 32'd1000000);
		send_reading(24'h7FFFFF);
		send_reading(24'h800000);
		settle();

		// largest gain against largest tare, then against zero tare
		write_reg(REG_GAIN, 32'hFFFFFFFF);
		write_reg(REG_TARE, 32'hFFFFFFFF);
		send_reading(24'h7FFFFF);
		settle();
		write_reg(REG_TARE, 32'd0);
		send_reading(24'h7FFFFF);
		send_reading(24'h7FFFFF);
		settle();

		// zero gain never clears the tare
		write_reg(REG_GAIN, 32'd0);
		send_reading(24'h7FFFFF);
		settle();

		// disable mid transfer and with the second reading pending
		write_reg(REG_GAIN, GAIN_RESET);
		send_broken(10);
		send_reading(24'h7FFFFF);
		settle();
		write_reg(REG_ENABLE, 32'd0);
		send_tick(1'b0);
		settle();
		write_reg(REG_ENABLE, 32'd1);
		send_reading(24'h123456);
		send_reading(24'hFEDCBA);
		settings = 5;

		while (sb.ticks < 1150) begin
			settle();
			r = $urandom_range(0, 99);
			if (r < 10)
				g = 32'd0;
			else if (r < 20)
				g = 32'hFFFFFFFF;
			else if (r < 40)
				g = GAIN_RESET;
			else
				g = $urandom;
			write_reg(REG_GAIN, g);
			r = $urandom_range(0, 99);
			if (r < 40)
				t = CFG_DATA_W'(sb.scaled_reading(pick_word() ^ TOP_BIT));
			else if (r < 55)
				t = 32'd0;
			else if (r < 65)
				t = 32'hFFFFFFFF;
			else
				t = $urandom;
			write_reg(REG_TARE, t);
			write_reg(REG_ENABLE, 32'd1);
			settings++;
			repeat ($urandom_range(6, 12)) begin
				gaps_on = ($urandom_range(0, 3) != 0);
				r = $urandom_range(0, 99);
				if (r < 80)
					send_reading(pick_word());
				else if (r < 88)
					repeat ($urandom_range(1, 8)) send_tick(rand_bit());
				else if (r < 94)
					send_broken($urandom_range(1, 48));
				else
					settle();
			end
		end

		settle();
		if (sb.expected_ticks.size() != 0)
			sb.report("results missing at end", sb.expected_ticks[0], '0);
		$display("run covered %0d ticks over %0d register settings", sb.ticks, settings);
		$display("weights: %0d in all, %0d above tare (%0d negative), %0d at or below tare",
			sb.weights, sb.over_cnt, sb.neg_cnt, sb.zero_cnt);
		if (sb.errors == 0)
			$display("load_cell_weight_reader_core regression: pass");
		else
			$display("load_cell_weight_reader_core regression: fail");
		$finish;
	end

endmodule
